@@ hdl/flsf_pkg.sv @@
// Package for the first/last substring finder.
// Holds sizing constants, register indexes and the result record type.
// No dependencies.
package flsf_pkg;

	// Longest line that is searched, and most pattern bytes
	localparam int LINE_MAX    = 1024;
	localparam int PATTERN_MAX = 8;

	// Field and counter widths
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 4;
	localparam int WORD_W  = 64;
	localparam int START_W = 10;
	localparam int POS_W   = $clog2(LINE_MAX + 1);
	localparam int IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int CFG_IDX_W = 1;

	// Register reset values
	localparam logic [WORD_W-1:0] PATTERN_WORD_RST = 64'h0000_0000_646C_756F;
	localparam logic [LEN_W-1:0]  PATTERN_LEN_RST  = 4'd4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 1'd1;

	// One line's result, as packed into the output tdata (highest bit first)
	typedef struct packed {
		logic               truncated;
		logic [START_W-1:0] last_start;
		logic               last_found;
		logic [START_W-1:0] first_start;
		logic               first_found;
	} flsf_result_t;

	localparam int RESULT_W = $bits(flsf_result_t);
	localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

endpackage

@@ hdl/flsf_cell.sv @@
// One window cell of the substring finder: holds one recent byte and
// compares the byte it is about to take with its pattern byte.
// Depends on flsf_pkg.
module flsf_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           shift_en,
	input  logic [flsf_pkg::IDX_W-1:0]     cell_idx,
	input  logic [flsf_pkg::BYTE_W-1:0]    byte_in,
	input  logic [flsf_pkg::WORD_W-1:0]    pattern_word,
	input  logic [flsf_pkg::LEN_W-1:0]     pattern_len,
	output logic [flsf_pkg::BYTE_W-1:0]    byte_q,
	output logic                           eq
);

	logic                         in_use;
	logic [flsf_pkg::LEN_W-1:0]   sel;
	logic [flsf_pkg::BYTE_W-1:0]  want;

	// Cell j holds window entry j; it checks pattern byte len-1-j
	assign in_use = flsf_pkg::LEN_W'(cell_idx) < pattern_len;
	assign sel    = pattern_len - 4'd1 - flsf_pkg::LEN_W'(cell_idx);
	assign want   = pattern_word[sel[2:0]*flsf_pkg::BYTE_W +: flsf_pkg::BYTE_W];
	assign eq     = !in_use || (byte_in == want);

	// Window byte moves one cell down the row on every stored byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= byte_in;
		end
	end

endmodule

@@ hdl/flsf_hit_rec.sv @@
// Per-line record of the substring finder: byte position, leftmost and
// rightmost match start, overflow flag. Depends on flsf_pkg.
module flsf_hit_rec (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          eol,
	input  logic                          all_eq,
	input  logic [flsf_pkg::LEN_W-1:0]    pattern_len,
	output logic                          store_en,
	output flsf_pkg::flsf_result_t        result
);

	localparam int WIDE_W = (flsf_pkg::POS_W > flsf_pkg::START_W) ?
		flsf_pkg::POS_W : flsf_pkg::START_W;

	logic [flsf_pkg::POS_W-1:0]   pos_q;
	logic [flsf_pkg::START_W-1:0] first_q;
	logic [flsf_pkg::START_W-1:0] last_q;
	logic                         seen_q;
	logic                         ovf_q;

	logic                         in_range;
	logic                         len_ok;
	logic                         hit;
	logic [flsf_pkg::POS_W-1:0]   pos_new;
	logic [WIDE_W-1:0]            start_wide;
	logic [flsf_pkg::START_W-1:0] start;
	logic                         seen_n;
	logic [flsf_pkg::START_W-1:0] first_n;
	logic [flsf_pkg::START_W-1:0] last_n;
	logic                         ovf_n;

	// Match decision for the byte now arriving
	assign in_range   = pos_q < flsf_pkg::POS_W'(flsf_pkg::LINE_MAX);
	assign pos_new    = pos_q + 1'b1;
	assign len_ok     = (pattern_len != '0) &&
		(pattern_len <= flsf_pkg::LEN_W'(flsf_pkg::PATTERN_MAX));
	assign hit        = in_range && len_ok && all_eq &&
		(pos_new >= flsf_pkg::POS_W'(pattern_len));
	assign start_wide = WIDE_W'(pos_new) - WIDE_W'(pattern_len);
	assign start      = start_wide[flsf_pkg::START_W-1:0];
	assign store_en   = step && in_range;

	// Record after this byte
	assign seen_n  = seen_q || hit;
	assign first_n = seen_q ? first_q : start;
	assign last_n  = hit ? start : last_q;
	assign ovf_n   = ovf_q || !in_range;

	always_comb begin
		result.first_found = seen_n;
		result.first_start = seen_n ? first_n : '0;
		result.last_found  = seen_n;
		result.last_start  = seen_n ? last_n : '0;
		result.truncated   = ovf_n;
	end

	// Update per byte, clear at end of line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			first_q <= '0;
			last_q  <= '0;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			if (eol) begin
				pos_q   <= '0;
				first_q <= '0;
				last_q  <= '0;
				seen_q  <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				if (in_range) begin
					pos_q <= pos_new;
				end
				first_q <= seen_n ? first_n : '0;
				last_q  <= seen_n ? last_n : '0;
				seen_q  <= seen_n;
				ovf_q   <= ovf_n;
			end
		end
	end

endmodule

@@ hdl/first_last_substring_finder.sv @@
// Channel  Dir  Fields (lowest bit up)
// s_*      in   tdata: line_byte[7:0]; tlast: end_of_line
// m_*      out  tdata: first_found, first_start[9:0], last_found,
//               last_start[9:0], line_truncated, zero pad
// cfg_*    in   index 0 pattern_word[63:0], index 1 pattern_len[3:0]
//
// One byte per cycle while s_tready is high: all window cells compare in the cycle a byte is taken.
// The line's result is in the output register the cycle after its last byte.
// s_tready drops only while a result waits and m_tready is low.
// Reset loads pattern "ould", length 4, and clears the line record.
// Top level of the first/last substring finder; depends on flsf_pkg,
// flsf_cell and flsf_hit_rec.
module first_last_substring_finder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [flsf_pkg::BYTE_W-1:0]          s_tdata,  // line_byte
	input  logic                                 s_tlast,  // end_of_line
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [flsf_pkg::OUT_W-1:0]           m_tdata,  // see table above
	input  logic                                 cfg_we,
	input  logic [flsf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [flsf_pkg::WORD_W-1:0]          cfg_wdata
);

	logic [flsf_pkg::WORD_W-1:0]  pattern_word_q;
	logic [flsf_pkg::LEN_W-1:0]   pattern_len_q;
	logic                         m_tvalid_q;
	logic [flsf_pkg::OUT_W-1:0]   m_tdata_q;

	logic                         step;
	logic                         store_en;
	logic [flsf_pkg::BYTE_W-1:0]  cell_in [flsf_pkg::PATTERN_MAX];
	logic [flsf_pkg::BYTE_W-1:0]  cell_q  [flsf_pkg::PATTERN_MAX];
	logic [flsf_pkg::PATTERN_MAX-1:0] cell_eq;
	flsf_pkg::flsf_result_t       result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_word_q <= flsf_pkg::PATTERN_WORD_RST;
			pattern_len_q  <= flsf_pkg::PATTERN_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				flsf_pkg::REG_PATTERN_WORD: pattern_word_q <= cfg_wdata;
				flsf_pkg::REG_PATTERN_LEN:  pattern_len_q  <= cfg_wdata[flsf_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Request handshake: take a byte unless a result is stuck
	assign s_tready = !m_tvalid_q || m_tready;
	assign step     = s_tvalid && s_tready;

	// Row of window cells, newest byte enters cell 0
	genvar j;
	generate
		for (j = 0; j < flsf_pkg::PATTERN_MAX; j++) begin : g_cell
			if (j == 0) begin : g_head
				assign cell_in[j] = s_tdata;
			end else begin : g_link
				assign cell_in[j] = cell_q[j-1];
			end
			flsf_cell u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.shift_en     (store_en),
				.cell_idx     (flsf_pkg::IDX_W'(j)),
				.byte_in      (cell_in[j]),
				.pattern_word (pattern_word_q),
				.pattern_len  (pattern_len_q),
				.byte_q       (cell_q[j]),
				.eq           (cell_eq[j])
			);
		end
	endgenerate

	// Match record for the current line
	flsf_hit_rec u_hit_rec (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.eol         (s_tlast),
		.all_eq      (&cell_eq),
		.pattern_len (pattern_len_q),
		.store_en    (store_en),
		.result      (result)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step && s_tlast) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && s_tlast) begin
			m_tdata_q <= flsf_pkg::OUT_W'(result);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTH
	// A stalled input means a result is waiting and not taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a pending result");

	// End of line always yields a result next cycle
	a_eol_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> m_tvalid)
		else $error("line end gave no result");

	// Both found flags agree
	a_found_agree: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == m_tdata[flsf_pkg::START_W+1]))
		else $error("first and last found flags differ");

	// No match reports zero start positions
	a_zero_start: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |->
		(m_tdata[2*flsf_pkg::START_W+1:1] == '0))
		else $error("start positions nonzero without a match");
`endif

endmodule
